>>> hdl/epu_pkg.sv
package epu_pkg;

    localparam int unsigned WORK_W = 34;
    localparam int unsigned PROD_W = 2 * WORK_W;

    typedef logic signed [WORK_W-1:0] work_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // opcodes
    localparam logic [2:0] OP_FORWARD  = 3'd0;
    localparam logic [2:0] OP_BACKWARD = 3'd1;
    localparam logic [2:0] OP_LEFT     = 3'd2;
    localparam logic [2:0] OP_RIGHT    = 3'd3;
    localparam logic [2:0] OP_LOOK     = 3'd4;
    localparam logic [2:0] OP_PLACE    = 3'd5;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOK_SENS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_UP_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_UP_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_UP_Z  = 3'd4;

    // angles, Q.16 degrees
    localparam logic signed [36:0] DEG_FULL    = 37'sd23592960;
    localparam logic signed [36:0] DEG_HALF    = 37'sd11796480;
    localparam logic signed [25:0] DEG_QUARTER = 26'sd5898240;
    localparam logic signed [32:0] PITCH_LIMIT = 33'sd5832704;
    localparam logic signed [36:0] WRAP_BIAS   = DEG_FULL * 37'sd512;
    localparam work_t DEG_TO_RAD_Q32  = 34'sd74961321;
    localparam work_t CORDIC_GAIN_Q30 = 34'sd652032874;

    // 360 degrees is 45 * 2^19 in Q.16: shift out 2^19, then divide by 45
    // with a reciprocal that is exact for quotients below 2^16
    localparam int unsigned WRAP_PRE_SHIFT   = 19;
    localparam int unsigned WRAP_RECIP_SHIFT = 21;
    localparam work_t       WRAP_RECIP       = 34'sd46604;

    // reciprocal square root seeds, Q.28
    localparam work_t RSQRT_SEED_0 = 34'sd429496730;
    localparam work_t RSQRT_SEED_1 = 34'sd308700774;
    localparam work_t RSQRT_SEED_2 = 34'sd220117074;
    localparam work_t RSQRT_SEED_3 = 34'sd171798692;

    localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [15:0]        delta_time;
        logic signed [31:0] angle_a;
        logic signed [31:0] angle_b;
        logic               constrain_pitch;
        logic signed [31:0] place_x;
        logic signed [31:0] place_y;
        logic signed [31:0] place_z;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } pose_t;

    // arctangent of 2^-i in Q.32 radians
    function automatic work_t atan_q32(input logic [4:0] i);
        work_t r;
        unique case (i)
            5'd0:    r = 34'sd3373259426;
            5'd1:    r = 34'sd1991351318;
            5'd2:    r = 34'sd1052175346;
            5'd3:    r = 34'sd534100635;
            5'd4:    r = 34'sd268086748;
            5'd5:    r = 34'sd134174063;
            5'd6:    r = 34'sd67103403;
            5'd7:    r = 34'sd33553749;
            5'd8:    r = 34'sd16777131;
            5'd9:    r = 34'sd8388597;
            5'd10:   r = 34'sd4194303;
            default: r = work_t'(1) <<< (6'd32 - {1'b0, i});
        endcase
        return r;
    endfunction

endpackage

>>> hdl/epu_mul.sv
module epu_mul
    import epu_pkg::*;
(
    input  logic  clk,
    input  work_t a,
    input  work_t b,
    output prod_t p
);

    prod_t p_reg;

    // registered signed product
    always_ff @(posedge clk)
    begin
        p_reg <= prod_t'(a) * prod_t'(b);
    end

    assign p = p_reg;

endmodule

>>> hdl/epu_cordic.sv
module epu_cordic
    import epu_pkg::*;
#(
    parameter int unsigned STEPS = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  work_t z_init,
    output logic  done,
    output work_t cos_out,
    output work_t sin_out
);

    localparam int unsigned CNT_W = $clog2(STEPS + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic [CNT_W-1:0] step_reg;
    logic             run_reg;
    logic             done_reg;
    work_t            x_reg, y_reg, z_reg;
    work_t            dx, dy, at;

    always_comb
    begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = atan_q32(5'(step_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one micro-rotation per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_GAIN_Q30;
            y_reg <= '0;
            z_reg <= z_init;
        end
        else if (run_reg)
        begin
            if (!z_reg[WORK_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule

>>> hdl/euler_camera_pose_update_unit.sv
// Euler-angle fly camera pose unit. Holds a camera position, yaw, pitch and
// the front, right and up unit vectors (Q2.14), and answers every command
// transfer with one pose transfer. Commands: forward, backward, left, right
// (move along front or right by speed times delta time, saturating), look
// (scale mouse offsets by the sensitivity, add to yaw and pitch, optional
// pitch clamp to +-89 degrees, rebuild the vectors) and place (set position,
// yaw and pitch, rebuild the vectors); unused opcodes return the pose as is.
// One command is worked at a time: cmd_stall is high from acceptance until
// the pose is loaded into the output register, and a new command may be
// taken while that pose still waits on pose_stall. Look and place work
// through two modulo-360 angle wraps (reciprocal multiply and subtract),
// a CORDIC sine/cosine pair for each angle, the raw front vector, three
// normalizations (power-of-two scaling steps, then Newton iterations)
// and two cross products. All products go through the single shared
// 34x34 multiplier, and the CORDIC does one step per cycle.
// Configuration writes are always accepted (cfg_ready stays high) and must
// be issued while no command is in flight.
module euler_camera_pose_update_unit
    import epu_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = 16,
    parameter int unsigned RSQRT_STEPS  = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_t                 cmd,
    output logic                 pose_valid,
    input  logic                 pose_stall,
    output pose_t                pose,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int unsigned NK_W = $clog2(RSQRT_STEPS + 1);
    localparam logic [NK_W-1:0] NK_LAST = NK_W'(RSQRT_STEPS - 1);

    localparam logic [1:0] SEL_FRONT = 2'd0;
    localparam logic [1:0] SEL_RIGHT = 2'd1;
    localparam logic [1:0] SEL_UP    = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH,
        S_MV_VEL, S_MV_VELR, S_MV_D, S_MV_DR,
        S_LK_YAW, S_LK_YAWR, S_LK_PITR,
        S_WR_MQ, S_WR_MR, S_WR_MD, S_WR_FIN,
        S_VC_ANG, S_VC_Z, S_VC_WAIT, S_VC_R0, S_VC_R1, S_VC_R2,
        S_NM_SCALE, S_NM_SQ, S_NM_SQA, S_NM_SEED,
        S_NW_A, S_NW_B, S_NW_C, S_NW_D, S_NW_E, S_NW_F,
        S_NM_OUT, S_NM_OUTR, S_NM_DONE,
        S_CR_M, S_CR_A,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [31:0]        speed_reg;
    logic [15:0]        sens_reg;
    logic signed [15:0] wup_reg [3];

    // pose
    logic signed [31:0] pos_reg   [3];
    logic signed [24:0] yaw_reg;
    logic signed [24:0] pitch_reg;
    logic signed [15:0] front_reg [3];
    logic signed [15:0] right_reg [3];
    logic signed [15:0] up_reg    [3];

    // working registers
    cmd_t               cmd_reg;
    work_t              vel_reg;
    logic [1:0]         idx_reg;
    logic [35:0]        acc_reg;
    logic signed [32:0] pitch_pre_reg;
    logic               wsel_reg;
    logic               asel_reg;
    logic               neg_reg;
    work_t              cy_reg, sy_reg, cp_reg, sp_reg;
    work_t              vec_reg [3];
    work_t              sacc_reg;
    work_t              t_reg;
    work_t              y_reg;
    work_t              tmp_reg;
    logic [NK_W-1:0]    nk_reg;
    logic signed [15:0] res_reg [3];
    logic [1:0]         nsel_reg;
    logic [2:0]         cj_reg;
    work_t              cacc_reg;
    pose_t              pose_reg;
    logic               pose_valid_reg;

    // shared multiplier
    work_t mul_a, mul_b;
    prod_t mul_p;

    epu_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // sine and cosine
    logic  cord_start, cord_done;
    work_t cord_z, cord_cos, cord_sin;

    epu_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .z_init  (cord_z),
        .done    (cord_done),
        .cos_out (cord_cos),
        .sin_out (cord_sin)
    );

    function automatic prod_t rnd_sh(input prod_t v, input int unsigned n);
        prod_t half;
        half = prod_t'(1) <<< (n - 1);
        return (v + half) >>> n;
    endfunction

    function automatic logic [35:0] wrap_init(input logic signed [32:0] v);
        logic signed [36:0] s;
        s = 37'(v) + WRAP_BIAS;
        return s[35:0];
    endfunction

    function automatic work_t abs_w(input work_t v);
        return v[WORK_W-1] ? -v : v;
    endfunction

    // combinational helpers
    logic               is_move, is_sub, use_front;
    logic signed [15:0] dir_comp;
    logic signed [35:0] move_d, move_sum;
    logic signed [31:0] move_sat;
    logic signed [32:0] yaw_sum, pitch_sum, pitch_clamped;
    logic [35:0]        wrap_rem;
    logic signed [36:0] wrap_res;
    logic signed [24:0] angle_sel;
    logic signed [25:0] angle_fold;
    logic               angle_neg;
    work_t              max_abs, a0, a1, a2;
    logic signed [35:0] norm_r;
    logic signed [15:0] norm_sat;
    logic signed [15:0] u_vec [3];
    logic signed [15:0] w_vec [3];
    logic [1:0]         cu_idx, cw_idx;

    always_comb
    begin
        is_move   = (cmd_reg.opcode == OP_FORWARD) || (cmd_reg.opcode == OP_BACKWARD)
                 || (cmd_reg.opcode == OP_LEFT) || (cmd_reg.opcode == OP_RIGHT);
        is_sub    = cmd_reg.opcode[0];
        use_front = (cmd_reg.opcode == OP_FORWARD) || (cmd_reg.opcode == OP_BACKWARD);
        dir_comp  = use_front ? front_reg[idx_reg] : right_reg[idx_reg];
        move_d    = 36'(rnd_sh(mul_p, 14));
        move_sum  = is_sub ? (36'(pos_reg[idx_reg]) - move_d)
                           : (36'(pos_reg[idx_reg]) + move_d);
        if (move_sum > 36'sd2147483647)
            move_sat = 32'sh7fffffff;
        else if (move_sum < -36'sd2147483648)
            move_sat = 32'sh80000000;
        else
            move_sat = move_sum[31:0];

        yaw_sum   = 33'(yaw_reg) + 33'(rnd_sh(mul_p, 16));
        pitch_sum = 33'(pitch_reg) + 33'(rnd_sh(mul_p, 16));
        pitch_clamped = pitch_sum;
        if (cmd_reg.constrain_pitch)
        begin
            if (pitch_sum > PITCH_LIMIT)
                pitch_clamped = PITCH_LIMIT;
            else if (pitch_sum < -PITCH_LIMIT)
                pitch_clamped = -PITCH_LIMIT;
        end

        // remainder of the biased angle once quotient * 360 is subtracted
        wrap_rem  = acc_reg - mul_p[35:0];
        wrap_res  = ($signed({1'b0, wrap_rem}) >= DEG_HALF)
                  ? ($signed({1'b0, wrap_rem}) - DEG_FULL) : $signed({1'b0, wrap_rem});

        // fold the angle into [-90, 90] and remember the cosine sign
        angle_sel  = asel_reg ? pitch_reg : yaw_reg;
        angle_fold = 26'(angle_sel);
        angle_neg  = 1'b0;
        if (26'(angle_sel) > DEG_QUARTER)
        begin
            angle_fold = 26'(DEG_HALF) - 26'(angle_sel);
            angle_neg  = 1'b1;
        end
        else if (26'(angle_sel) < -DEG_QUARTER)
        begin
            angle_fold = -26'(DEG_HALF) - 26'(angle_sel);
            angle_neg  = 1'b1;
        end

        a0 = abs_w(vec_reg[0]);
        a1 = abs_w(vec_reg[1]);
        a2 = abs_w(vec_reg[2]);
        max_abs = a0;
        if (a1 > max_abs)
            max_abs = a1;
        if (a2 > max_abs)
            max_abs = a2;

        norm_r = 36'(rnd_sh(mul_p, 29));
        if (norm_r > 36'sd32767)
            norm_sat = 16'sh7fff;
        else if (norm_r < -36'sd32768)
            norm_sat = 16'sh8000;
        else
            norm_sat = norm_r[15:0];

        // cross product operands: world_up x front, then front x right
        for (int i = 0; i < 3; i++)
        begin
            u_vec[i] = (nsel_reg == SEL_RIGHT) ? wup_reg[i] : front_reg[i];
            w_vec[i] = (nsel_reg == SEL_RIGHT) ? front_reg[i] : right_reg[i];
        end
        unique case (cj_reg)
            3'd0:    begin cu_idx = 2'd1; cw_idx = 2'd2; end
            3'd1:    begin cu_idx = 2'd2; cw_idx = 2'd1; end
            3'd2:    begin cu_idx = 2'd2; cw_idx = 2'd0; end
            3'd3:    begin cu_idx = 2'd0; cw_idx = 2'd2; end
            3'd4:    begin cu_idx = 2'd0; cw_idx = 2'd1; end
            default: begin cu_idx = 2'd1; cw_idx = 2'd0; end
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MV_VEL:
            begin
                mul_a = work_t'({2'b00, speed_reg});
                mul_b = work_t'({18'd0, cmd_reg.delta_time});
            end
            S_MV_D:
            begin
                mul_a = vel_reg;
                mul_b = work_t'(dir_comp);
            end
            S_LK_YAW:
            begin
                mul_a = work_t'(cmd_reg.angle_a);
                mul_b = work_t'({18'd0, sens_reg});
            end
            S_LK_YAWR:
            begin
                mul_a = work_t'(cmd_reg.angle_b);
                mul_b = work_t'({18'd0, sens_reg});
            end
            S_WR_MQ:
            begin
                mul_a = work_t'(acc_reg >> WRAP_PRE_SHIFT);
                mul_b = WRAP_RECIP;
            end
            S_WR_MD:
            begin
                mul_a = tmp_reg;
                mul_b = work_t'(DEG_FULL);
            end
            S_VC_ANG:
            begin
                mul_a = work_t'(angle_fold);
                mul_b = DEG_TO_RAD_Q32;
            end
            S_VC_R0:
            begin
                mul_a = cy_reg;
                mul_b = cp_reg;
            end
            S_VC_R1:
            begin
                mul_a = sy_reg;
                mul_b = cp_reg;
            end
            S_NM_SQ:
            begin
                mul_a = vec_reg[idx_reg];
                mul_b = vec_reg[idx_reg];
            end
            S_NW_A:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            S_NW_C:
            begin
                mul_a = t_reg;
                mul_b = tmp_reg;
            end
            S_NW_E:
            begin
                mul_a = y_reg;
                mul_b = tmp_reg;
            end
            S_NM_OUT:
            begin
                mul_a = vec_reg[idx_reg];
                mul_b = y_reg;
            end
            S_CR_M:
            begin
                mul_a = work_t'(u_vec[cu_idx]);
                mul_b = work_t'(w_vec[cw_idx]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign cord_start = (state_reg == S_VC_Z);
    assign cord_z     = work_t'(rnd_sh(mul_p, 16));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            speed_reg      <= 32'd163840;
            sens_reg       <= 16'd6554;
            wup_reg[0]     <= '0;
            wup_reg[1]     <= UNIT_Q14;
            wup_reg[2]     <= '0;
            pos_reg[0]     <= '0;
            pos_reg[1]     <= '0;
            pos_reg[2]     <= '0;
            yaw_reg        <= '0;
            pitch_reg      <= '0;
            front_reg[0]   <= UNIT_Q14;
            front_reg[1]   <= '0;
            front_reg[2]   <= '0;
            right_reg[0]   <= '0;
            right_reg[1]   <= '0;
            right_reg[2]   <= -UNIT_Q14;
            up_reg[0]      <= '0;
            up_reg[1]      <= UNIT_Q14;
            up_reg[2]      <= '0;
            cmd_reg        <= '0;
            vel_reg        <= '0;
            idx_reg        <= '0;
            acc_reg        <= '0;
            pitch_pre_reg  <= '0;
            wsel_reg       <= 1'b0;
            asel_reg       <= 1'b0;
            neg_reg        <= 1'b0;
            cy_reg         <= '0;
            sy_reg         <= '0;
            cp_reg         <= '0;
            sp_reg         <= '0;
            vec_reg[0]     <= '0;
            vec_reg[1]     <= '0;
            vec_reg[2]     <= '0;
            sacc_reg       <= '0;
            t_reg          <= '0;
            y_reg          <= '0;
            tmp_reg        <= '0;
            nk_reg         <= '0;
            res_reg[0]     <= '0;
            res_reg[1]     <= '0;
            res_reg[2]     <= '0;
            nsel_reg       <= SEL_FRONT;
            cj_reg         <= '0;
            cacc_reg       <= '0;
            pose_reg       <= '0;
            pose_valid_reg <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MOVE_SPEED: speed_reg  <= cfg_data;
                    REG_LOOK_SENS:  sens_reg   <= cfg_data[15:0];
                    REG_WORLD_UP_X: wup_reg[0] <= cfg_data[15:0];
                    REG_WORLD_UP_Y: wup_reg[1] <= cfg_data[15:0];
                    REG_WORLD_UP_Z: wup_reg[2] <= cfg_data[15:0];
                    default:        ;
                endcase
            end

            // drop the pose once it is taken; S_DONE reloads it itself
            if (pose_valid_reg && !pose_stall && (state_reg != S_DONE))
                pose_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    if (is_move)
                        state_reg <= S_MV_VEL;
                    else if (cmd_reg.opcode == OP_LOOK)
                        state_reg <= S_LK_YAW;
                    else if (cmd_reg.opcode == OP_PLACE)
                    begin
                        pos_reg[0]    <= cmd_reg.place_x;
                        pos_reg[1]    <= cmd_reg.place_y;
                        pos_reg[2]    <= cmd_reg.place_z;
                        acc_reg       <= wrap_init(33'(cmd_reg.angle_a));
                        pitch_pre_reg <= 33'(cmd_reg.angle_b);
                        wsel_reg      <= 1'b0;
                        state_reg     <= S_WR_MQ;
                    end
                    else
                        state_reg <= S_DONE;
                end

                // moves: velocity, then one component per pass
                S_MV_VEL:
                    state_reg <= S_MV_VELR;
                S_MV_VELR:
                begin
                    vel_reg   <= work_t'(rnd_sh(mul_p, 16));
                    idx_reg   <= '0;
                    state_reg <= S_MV_D;
                end
                S_MV_D:
                    state_reg <= S_MV_DR;
                S_MV_DR:
                begin
                    pos_reg[idx_reg] <= move_sat;
                    if (idx_reg == 2'd2)
                        state_reg <= S_DONE;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_MV_D;
                    end
                end

                // look: scaled offsets
                S_LK_YAW:
                    state_reg <= S_LK_YAWR;
                S_LK_YAWR:
                begin
                    acc_reg   <= wrap_init(yaw_sum);
                    state_reg <= S_LK_PITR;
                end
                S_LK_PITR:
                begin
                    pitch_pre_reg <= pitch_clamped;
                    wsel_reg      <= 1'b0;
                    state_reg     <= S_WR_MQ;
                end

                // reduce modulo 360 degrees: reciprocal quotient, then subtract
                S_WR_MQ:
                    state_reg <= S_WR_MR;
                S_WR_MR:
                begin
                    tmp_reg   <= work_t'(mul_p >>> WRAP_RECIP_SHIFT);
                    state_reg <= S_WR_MD;
                end
                S_WR_MD:
                    state_reg <= S_WR_FIN;
                S_WR_FIN:
                begin
                    if (!wsel_reg)
                    begin
                        yaw_reg   <= wrap_res[24:0];
                        acc_reg   <= wrap_init(pitch_pre_reg);
                        wsel_reg  <= 1'b1;
                        state_reg <= S_WR_MQ;
                    end
                    else
                    begin
                        pitch_reg <= wrap_res[24:0];
                        asel_reg  <= 1'b0;
                        state_reg <= S_VC_ANG;
                    end
                end

                // sine and cosine of yaw, then pitch
                S_VC_ANG:
                begin
                    neg_reg   <= angle_neg;
                    state_reg <= S_VC_Z;
                end
                S_VC_Z:
                    state_reg <= S_VC_WAIT;
                S_VC_WAIT:
                begin
                    if (cord_done)
                    begin
                        if (!asel_reg)
                        begin
                            cy_reg    <= neg_reg ? -cord_cos : cord_cos;
                            sy_reg    <= cord_sin;
                            asel_reg  <= 1'b1;
                            state_reg <= S_VC_ANG;
                        end
                        else
                        begin
                            cp_reg    <= neg_reg ? -cord_cos : cord_cos;
                            sp_reg    <= cord_sin;
                            state_reg <= S_VC_R0;
                        end
                    end
                end
                S_VC_R0:
                    state_reg <= S_VC_R1;
                S_VC_R1:
                begin
                    vec_reg[0] <= work_t'(rnd_sh(mul_p, 30));
                    state_reg  <= S_VC_R2;
                end
                S_VC_R2:
                begin
                    vec_reg[1] <= sp_reg;
                    vec_reg[2] <= work_t'(rnd_sh(mul_p, 30));
                    nsel_reg   <= SEL_FRONT;
                    state_reg  <= S_NM_SCALE;
                end

                // normalize: scale by powers of two into [16384, 32768)
                S_NM_SCALE:
                begin
                    if (max_abs == '0)
                    begin
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        res_reg[2] <= '0;
                        state_reg  <= S_NM_DONE;
                    end
                    else if (max_abs >= work_t'(32768))
                    begin
                        for (int i = 0; i < 3; i++)
                            vec_reg[i] <= vec_reg[i] >>> 1;
                    end
                    else if (max_abs < work_t'(16384))
                    begin
                        for (int i = 0; i < 3; i++)
                            vec_reg[i] <= vec_reg[i] <<< 1;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        sacc_reg  <= '0;
                        state_reg <= S_NM_SQ;
                    end
                end
                S_NM_SQ:
                    state_reg <= S_NM_SQA;
                S_NM_SQA:
                begin
                    sacc_reg <= sacc_reg + work_t'(mul_p);
                    if (idx_reg == 2'd2)
                        state_reg <= S_NM_SEED;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_NM_SQ;
                    end
                end
                S_NM_SEED:
                begin
                    t_reg <= sacc_reg >>> 2;
                    priority if ((sacc_reg >>> 2) < work_t'(34'sd1 <<< 27))
                        y_reg <= RSQRT_SEED_0;
                    else if ((sacc_reg >>> 2) < work_t'(34'sd1 <<< 28))
                        y_reg <= RSQRT_SEED_1;
                    else if ((sacc_reg >>> 2) < work_t'(34'sd1 <<< 29))
                        y_reg <= RSQRT_SEED_2;
                    else
                        y_reg <= RSQRT_SEED_3;
                    nk_reg    <= '0;
                    state_reg <= S_NW_A;
                end

                // Newton step: y = y * (3 - t*y*y) / 2 in Q.28
                S_NW_A:
                    state_reg <= S_NW_B;
                S_NW_B:
                begin
                    tmp_reg   <= work_t'(mul_p >>> 28);
                    state_reg <= S_NW_C;
                end
                S_NW_C:
                    state_reg <= S_NW_D;
                S_NW_D:
                begin
                    tmp_reg   <= work_t'(34'sd3 <<< 28) - work_t'(mul_p >>> 28);
                    state_reg <= S_NW_E;
                end
                S_NW_E:
                    state_reg <= S_NW_F;
                S_NW_F:
                begin
                    y_reg <= work_t'(mul_p >>> 29);
                    if (nk_reg == NK_LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_NM_OUT;
                    end
                    else
                    begin
                        nk_reg    <= nk_reg + 1'b1;
                        state_reg <= S_NW_A;
                    end
                end

                S_NM_OUT:
                    state_reg <= S_NM_OUTR;
                S_NM_OUTR:
                begin
                    res_reg[idx_reg] <= norm_sat;
                    if (idx_reg == 2'd2)
                        state_reg <= S_NM_DONE;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_NM_OUT;
                    end
                end
                S_NM_DONE:
                begin
                    cj_reg <= '0;
                    unique case (nsel_reg)
                        SEL_FRONT:
                        begin
                            for (int i = 0; i < 3; i++)
                                front_reg[i] <= res_reg[i];
                            nsel_reg  <= SEL_RIGHT;
                            state_reg <= S_CR_M;
                        end
                        SEL_RIGHT:
                        begin
                            for (int i = 0; i < 3; i++)
                                right_reg[i] <= res_reg[i];
                            nsel_reg  <= SEL_UP;
                            state_reg <= S_CR_M;
                        end
                        default:
                        begin
                            for (int i = 0; i < 3; i++)
                                up_reg[i] <= res_reg[i];
                            state_reg <= S_DONE;
                        end
                    endcase
                end

                // cross product, two products per component
                S_CR_M:
                    state_reg <= S_CR_A;
                S_CR_A:
                begin
                    if (!cj_reg[0])
                    begin
                        cacc_reg <= work_t'(mul_p);
                    end
                    else
                    begin
                        vec_reg[cj_reg[2:1]] <= cacc_reg - work_t'(mul_p);
                    end
                    if (cj_reg == 3'd5)
                        state_reg <= S_NM_SCALE;
                    else
                    begin
                        cj_reg    <= cj_reg + 1'b1;
                        state_reg <= S_CR_M;
                    end
                end

                // hold until the output register is free
                S_DONE:
                begin
                    if (!pose_valid_reg || !pose_stall)
                    begin
                        pose_reg.pos_x   <= pos_reg[0];
                        pose_reg.pos_y   <= pos_reg[1];
                        pose_reg.pos_z   <= pos_reg[2];
                        pose_reg.front_x <= front_reg[0];
                        pose_reg.front_y <= front_reg[1];
                        pose_reg.front_z <= front_reg[2];
                        pose_reg.right_x <= right_reg[0];
                        pose_reg.right_y <= right_reg[1];
                        pose_reg.right_z <= right_reg[2];
                        pose_reg.up_x    <= up_reg[0];
                        pose_reg.up_y    <= up_reg[1];
                        pose_reg.up_z    <= up_reg[2];
                        pose_valid_reg   <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign cmd_stall  = (state_reg != S_IDLE);
    assign pose_valid = pose_valid_reg;
    assign pose       = pose_reg;
    assign cfg_ready  = 1'b1;

endmodule
